// ----- sv/bpl_pkg.sv -----
// ----------------------------------------------------------------------------
// bpl_pkg
// Shared types and constants for the bounded positional list.
// ----------------------------------------------------------------------------
package bpl_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = 8;
    localparam int CMD_W      = 3;
    localparam int ST_W       = 2;
    localparam int OUT_CNT_W  = 5;
    localparam int OUT_DATA_W = 32;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [DEPTH-1:0]      t_occ;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND     = 3'd0,
        CMD_PREPEND    = 3'd1,
        CMD_REMOVE_BK  = 3'd2,
        CMD_REMOVE_FR  = 3'd3,
        CMD_REMOVE_POS = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_TAKE_LEFT,
        OP_TAKE_RIGHT,
        OP_CLEAR
    } t_cell_op;

    typedef t_cell_op [DEPTH-1:0] t_op_vec;

    // per-command control handed from the controller to the cell row
    typedef struct packed {
        t_op_vec ops;
        t_data   din;
    } t_row_ctrl;

endpackage

// ----- sv/bpl_if.sv -----
// ----------------------------------------------------------------------------
// bpl_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface bpl_in_if
    import bpl_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [31:0]      data_value;
    logic [POS_W-1:0]        position;

    modport source (output valid, command, data_value, position, input ready);
    modport sink   (input valid, command, data_value, position, output ready);
endinterface

interface bpl_out_if
    import bpl_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [ST_W-1:0]             status;
    logic [OUT_CNT_W-1:0]        entry_count;
    logic signed [OUT_DATA_W-1:0] front_value;
    logic signed [OUT_DATA_W-1:0] back_value;

    modport source (output valid, status, entry_count, front_value, back_value,
                    input ready);
    modport sink   (input valid, status, entry_count, front_value, back_value,
                    output ready);
endinterface

// ----- sv/bounded_positional_list_core.sv -----
// ----------------------------------------------------------------------------
// bounded_positional_list_core
// Bounded ordered list held in a row of shifting cells, front at cell 0.
// ----------------------------------------------------------------------------
// The cells update at the accepting edge; the result register loads front,
// back and count once the output register is free or its word is taken.
// Throughput: one command per cycle unless results stall; one row update each.
// Reset: count and occupied flags clear, no result pending; cell values are
// left as they are and are never read before they are written.
module bounded_positional_list_core
    import bpl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpl_in_if.sink    i_in,
    bpl_out_if.source o_out
);

    t_row_ctrl w_row;
    t_status   w_status;
    t_count    w_count;
    t_data     w_val [DEPTH];
    t_occ      w_occ;
    logic      w_accept;
    logic      w_move;

    logic      r_pend;
    t_status   r_pend_status;
    logic      r_out_valid;
    t_status   r_status;
    t_count    r_count;
    t_data     r_front;
    t_data     r_back;
    t_data     w_back;

    assign w_move      = r_pend && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_pend || w_move;
    assign w_accept    = i_in.valid && i_in.ready;

    bpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_command  (i_in.command),
        .i_din      (DATA_WIDTH'($unsigned(i_in.data_value))),
        .i_position (i_in.position),
        .o_row      (w_row),
        .o_status   (w_status),
        .o_count    (w_count)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_data left_val, right_val;
        logic  left_occ, right_occ;
        if (g == 0) begin : g_first
            assign left_val = '0;
            assign left_occ = 1'b1;
        end else begin : g_mid
            assign left_val = w_val[g-1];
            assign left_occ = w_occ[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_val = '0;
            assign right_occ = 1'b0;
        end else begin : g_inner
            assign right_val = w_val[g+1];
            assign right_occ = w_occ[g+1];
        end
        bpl_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (w_row.ops[g]),
            .i_din       (w_row.din),
            .i_left_val  (left_val),
            .i_left_occ  (left_occ),
            .i_right_val (right_val),
            .i_right_occ (right_occ),
            .o_val       (w_val[g]),
            .o_occ       (w_occ[g])
        );
    end

    // back word: the one occupied cell whose right neighbor is free
    always_comb begin
        logic last;
        w_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i == DEPTH - 1) last = w_occ[i];
            else                last = w_occ[i] && !w_occ[i+1];
            if (last) w_back = w_back | w_val[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_pend_status <= w_status;
        if (w_move) begin
            r_status <= r_pend_status;
            r_count  <= w_count;
            r_front  <= w_occ[0] ? w_val[0] : '0;
            r_back   <= w_back;
        end
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept)    r_pend <= 1'b1;
            else if (w_move) r_pend <= 1'b0;
            if (w_move)             r_out_valid <= 1'b1;
            else if (o_out.ready)   r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.entry_count = OUT_CNT_W'(r_count);
    assign o_out.front_value = OUT_DATA_W'(r_front);
    assign o_out.back_value  = OUT_DATA_W'(r_back);

`ifndef SYNTHESIS
    a_occ_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_occ) == int'(w_count))
        else $error("occupied cells disagree with count");

    a_occ_packed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ + 1'b1) & w_occ) == '0)
        else $error("occupied cells not packed at the front");

    a_full_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_count == t_count'(DEPTH) &&
         (i_in.command == CMD_APPEND || i_in.command == CMD_PREPEND))
        |=> (w_count == t_count'(DEPTH) && r_pend_status == ST_FULL))
        else $error("add to full list changed the list");

    a_no_overrun : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !w_move) |-> !w_accept)
        else $error("word accepted while result stage blocked");
`endif

endmodule

// ----- sv/bpl_cell.sv -----
// ----------------------------------------------------------------------------
// bpl_cell
// One list slot: a value and an occupied flag, shifted to or from neighbors.
// ----------------------------------------------------------------------------
module bpl_cell
    import bpl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cell_op i_op,
    input  t_data    i_din,
    input  t_data    i_left_val,
    input  logic     i_left_occ,
    input  t_data    i_right_val,
    input  logic     i_right_occ,
    output t_data    o_val,
    output logic     o_occ
);

    t_data r_val, n_val;
    logic  r_occ, n_occ;

    always_comb begin
        n_val = r_val;
        n_occ = r_occ;
        case (i_op)
            OP_HOLD: begin
            end
            OP_LOAD: begin
                n_val = i_din;
                n_occ = 1'b1;
            end
            OP_TAKE_LEFT: begin
                n_val = i_left_val;
                n_occ = i_left_occ;
            end
            OP_TAKE_RIGHT: begin
                n_val = i_right_val;
                n_occ = i_right_occ;
            end
            OP_CLEAR: begin
                n_occ = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_val = r_val;
    assign o_occ = r_occ;

endmodule

// ----- sv/bpl_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpl_ctrl
// Command decode: status, entry count and the per-cell operation vector.
// ----------------------------------------------------------------------------
module bpl_ctrl
    import bpl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [CMD_W-1:0] i_command,
    input  t_data            i_din,
    input  logic [POS_W-1:0] i_position,
    output t_row_ctrl        o_row,
    output t_status          o_status,
    output t_count           o_count
);

    t_count           r_count, n_count;
    t_status          w_status;
    logic [POS_W-1:0] w_slot;
    logic [POS_W-1:0] w_cnt_pos;
    logic             w_full;
    logic             w_empty;

    assign w_full    = (r_count == t_count'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_cnt_pos = POS_W'(r_count);

    always_comb begin
        w_status = ST_OK;
        w_slot   = '0;
        case (i_command)
            CMD_APPEND, CMD_PREPEND: begin
                if (w_full) w_status = ST_FULL;
            end
            CMD_REMOVE_BK, CMD_REMOVE_FR: begin
                if (w_empty) w_status = ST_EMPTY;
            end
            CMD_REMOVE_POS: begin
                if (i_position == '0 || i_position > w_cnt_pos) w_status = ST_INVALID;
                w_slot = i_position - 1'b1;
            end
            default: w_status = ST_INVALID;
        endcase
    end

    always_comb begin
        logic             apply;
        logic [POS_W-1:0] idx;
        apply       = i_accept && (w_status == ST_OK);
        o_row.din   = i_din;
        n_count     = r_count;
        for (int i = 0; i < DEPTH; i++) begin
            idx = POS_W'(i);
            o_row.ops[i] = OP_HOLD;
            if (apply) begin
                case (i_command)
                    CMD_APPEND: begin
                        if (idx == w_cnt_pos) o_row.ops[i] = OP_LOAD;
                    end
                    CMD_PREPEND: begin
                        if (i == 0) o_row.ops[i] = OP_LOAD;
                        else if (idx <= w_cnt_pos) o_row.ops[i] = OP_TAKE_LEFT;
                    end
                    CMD_REMOVE_BK: begin
                        if (idx == w_cnt_pos - 1'b1) o_row.ops[i] = OP_CLEAR;
                    end
                    CMD_REMOVE_FR: begin
                        if (idx < w_cnt_pos) o_row.ops[i] = OP_TAKE_RIGHT;
                    end
                    CMD_REMOVE_POS: begin
                        if (idx >= w_slot && idx < w_cnt_pos) o_row.ops[i] = OP_TAKE_RIGHT;
                    end
                    default: o_row.ops[i] = OP_HOLD;
                endcase
            end
        end
        if (apply) begin
            case (i_command)
                CMD_APPEND, CMD_PREPEND: n_count = r_count + 1'b1;
                CMD_REMOVE_BK, CMD_REMOVE_FR, CMD_REMOVE_POS: n_count = r_count - 1'b1;
                default: n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_status = w_status;
    assign o_count  = r_count;

endmodule

// ----- test/tb_bounded_positional_list_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_positional_list_core
// Self-checking bench for the bounded positional list: commands go in over a
// valid/ready channel, a local list model predicts each result word, and the
// monitor checks every returned word field by field, in order.
// ----------------------------------------------------------------------------
module tb_bounded_positional_list_core;
    import bpl_pkg::*;

    localparam int CMD_MAX        = (1 << CMD_W) - 1;
    localparam int IDLE_PCT       = 32;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic signed [31:0] value;
        logic [POS_W-1:0]   pos;
    } t_list_cmd;

    typedef struct {
        t_status                      status;
        logic [OUT_CNT_W-1:0]         count;
        logic signed [OUT_DATA_W-1:0] front;
        logic signed [OUT_DATA_W-1:0] back;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    bpl_in_if  cmd_ch ();
    bpl_out_if res_ch ();

    bounded_positional_list_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    t_list_cmd    pending_cmds[$];
    t_list_result list_results[$];

    // local copy of the list, front at cell 0
    t_data list_cells [DEPTH];
    int    list_len     = 0;
    int    mismatches   = 0;
    int    holdoff_left = HOLDOFF_CYCLES;
    int    stall_cycles = 0;
    bit    burst_phase  = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void drop_cell(input int slot);
        for (int i = slot; i + 1 < list_len; i++)
            list_cells[i] = list_cells[i + 1];
        list_len--;
    endfunction

    task automatic predict_list_cmd(input logic [CMD_W-1:0] cmd,
                                    input logic signed [31:0] val,
                                    input logic [POS_W-1:0] pos);
        t_list_result r;
        r.status = ST_OK;
        case (cmd)
            CMD_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_cells[list_len] = val;
                    list_len++;
                end
            end
            CMD_PREPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > 0; i--)
                        list_cells[i] = list_cells[i - 1];
                    list_cells[0] = val;
                    list_len++;
                end
            end
            CMD_REMOVE_BK: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            CMD_REMOVE_FR: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else drop_cell(0);
            end
            CMD_REMOVE_POS: begin
                if (int'(pos) < 1 || int'(pos) > list_len) r.status = ST_INVALID;
                else drop_cell(int'(pos) - 1);
            end
            default: r.status = ST_INVALID;
        endcase
        r.count = OUT_CNT_W'(list_len);
        r.front = (list_len == 0) ? '0 : list_cells[0];
        r.back  = (list_len == 0) ? '0 : list_cells[list_len - 1];
        list_results.push_back(r);
    endtask

    function automatic t_list_cmd make_cmd(input logic [CMD_W-1:0] cmd,
                                           input logic signed [31:0] val,
                                           input int pos);
        t_list_cmd c;
        c.cmd   = cmd;
        c.value = val;
        c.pos   = POS_W'(pos);
        return c;
    endfunction

    // growing segments favor adds so the list reaches full, shrinking ones
    // favor removes so it drains back to empty
    function automatic t_list_cmd rand_list_cmd(input bit growing);
        t_list_cmd c;
        int        roll;
        int        add_pct;
        roll    = $urandom_range(99);
        add_pct = growing ? 65 : 30;
        if (roll < 3)
            c.cmd = CMD_W'($urandom_range(CMD_MAX, int'(CMD_REMOVE_POS) + 1));
        else if (roll < 3 + add_pct)
            c.cmd = $urandom_range(1) ? CMD_APPEND : CMD_PREPEND;
        else begin
            case ($urandom_range(3))
                0:       c.cmd = CMD_REMOVE_BK;
                1:       c.cmd = CMD_REMOVE_FR;
                default: c.cmd = CMD_REMOVE_POS;
            endcase
        end
        case ($urandom_range(9))
            0:       c.value = 32'sh7fffffff;
            1:       c.value = 32'sh80000000;
            2:       c.value = '0;
            3:       c.value = '1;
            default: c.value = $urandom;
        endcase
        if ($urandom_range(99) < 85) c.pos = POS_W'($urandom_range(DEPTH, 1));
        else c.pos = POS_W'($urandom_range((1 << POS_W) - 1, 0));
        return c;
    endfunction

    // driver: one word per handshake, random gaps except in the burst phase
    always @(posedge i_clk) begin
        t_list_cmd nxt;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready)
                predict_list_cmd(cmd_ch.command, cmd_ch.data_value, cmd_ch.position);
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (pending_cmds.size() != 0 &&
                    (burst_phase || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_cmds.pop_front();
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.command    <= nxt.cmd;
                    cmd_ch.data_value <= nxt.value;
                    cmd_ch.position   <= nxt.pos;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result ready: long hold-off at the start of the burst so the core backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (burst_phase && holdoff_left > 0) begin
            res_ch.ready <= 1'b0;
            holdoff_left--;
        end else if (burst_phase) begin
            res_ch.ready <= 1'b1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (list_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word with none pending: %s",
                             $realtime,
                             $sformatf("st=%0d cnt=%0d f=%0d b=%0d",
                                       res_ch.status, res_ch.entry_count,
                                       res_ch.front_value, res_ch.back_value));
            end else begin
                want = list_results.pop_front();
                if (res_ch.status !== want.status ||
                    res_ch.entry_count !== want.count ||
                    res_ch.front_value !== want.front ||
                    res_ch.back_value !== want.back) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch exp %s, got %s", $realtime,
                                 $sformatf("st=%0d cnt=%0d f=%0d b=%0d",
                                           want.status, want.count,
                                           want.front, want.back),
                                 $sformatf("st=%0d cnt=%0d f=%0d b=%0d",
                                           res_ch.status, res_ch.entry_count,
                                           res_ch.front_value, res_ch.back_value));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("** bounded_positional_list_core: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = CMD_APPEND;
        cmd_ch.data_value = '0;
        cmd_ch.position   = '0;
        res_ch.ready      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list removes, bad code, fill to full, edge positions
        @(negedge i_clk);
        pending_cmds.push_back(make_cmd(CMD_REMOVE_BK, 32'sd5, 1));
        pending_cmds.push_back(make_cmd(CMD_REMOVE_FR, 32'sd5, 1));
        pending_cmds.push_back(make_cmd(CMD_REMOVE_POS, 32'sd5, 0));
        pending_cmds.push_back(make_cmd(CMD_W'(CMD_MAX), 32'sd5, 1));
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 4)
                0: pending_cmds.push_back(make_cmd(CMD_APPEND, 32'sh7fffffff, i));
                1: pending_cmds.push_back(make_cmd(CMD_PREPEND, 32'sh80000000, i));
                2: pending_cmds.push_back(make_cmd(CMD_APPEND, -32'sd1, i));
                default: pending_cmds.push_back(make_cmd(CMD_PREPEND, 32'(i), i));
            endcase
        end
        pending_cmds.push_back(make_cmd(CMD_APPEND, 32'sd77, 1));
        pending_cmds.push_back(make_cmd(CMD_REMOVE_POS, 32'sd0, DEPTH + 1));
        pending_cmds.push_back(make_cmd(CMD_REMOVE_POS, 32'sd0, DEPTH));
        pending_cmds.push_back(make_cmd(CMD_REMOVE_POS, 32'sd0, 1));
        pending_cmds.push_back(make_cmd(CMD_REMOVE_BK, 32'sd0, 1));
        pending_cmds.push_back(make_cmd(CMD_REMOVE_FR, 32'sd0, 1));
        while (pending_cmds.size() != 0) @(negedge i_clk);

        for (int i = 0; i < 150; i++)
            pending_cmds.push_back(rand_list_cmd(((i / 20) % 2) == 0));
        while (pending_cmds.size() != 0) @(negedge i_clk);

        // burst: no idling on either side, result side holds off first
        for (int i = 0; i < 100; i++)
            pending_cmds.push_back(rand_list_cmd(((i / 25) % 2) == 0));
        burst_phase = 1'b1;
        while (pending_cmds.size() != 0) @(negedge i_clk);
        burst_phase = 1'b0;

        for (int i = 0; i < 150; i++)
            pending_cmds.push_back(rand_list_cmd(((i / 20) % 2) == 0));
        while (pending_cmds.size() != 0 || cmd_ch.valid) @(negedge i_clk);
        while (list_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && list_results.size() == 0) begin
            $display("** bounded_positional_list_core: PASSED **");
        end else begin
            $display("** bounded_positional_list_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/bpl_pkg.sv
sv/bpl_if.sv
sv/bpl_cell.sv
sv/bpl_ctrl.sv
sv/bounded_positional_list_core.sv
test/tb_bounded_positional_list_core.sv
